// ===== rtl/rmc_pkg.sv =====
// Shared types, constants and decode functions for the RMC field extractor.
// No dependencies.
`default_nettype none

package rmc_pkg;

	localparam int unsigned LINE_MAX_DEF    = 128;
	localparam int unsigned FIELD_CHARS_DEF = 16;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	localparam logic [7:0] PREFIX_LEN  = 8'd6;
	localparam logic [7:0] MATCH_MIN   = 8'd7;
	localparam logic [7:0] COUNT_SAT   = 8'd255;
	localparam logic [3:0] FLD_LAST    = 4'd11;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam logic [3:0] FID_TIME   = 4'd0;
	localparam logic [3:0] FID_STATUS = 4'd1;
	localparam logic [3:0] FID_LAT    = 4'd2;
	localparam logic [3:0] FID_NS     = 4'd3;
	localparam logic [3:0] FID_LON    = 4'd4;
	localparam logic [3:0] FID_EW     = 4'd5;
	localparam logic [3:0] FID_SPEED  = 4'd6;
	localparam logic [3:0] FID_COURSE = 4'd7;
	localparam logic [3:0] FID_MAGVAR = 4'd8;

	typedef struct packed {
		logic       kind;
		logic [3:0] field_id;
		logic [3:0] position;
		logic [7:0] char_value;
		logic       overlong;
	} rmc_res_t;

	typedef struct packed {
		logic       keep_f;
		logic       multi;
		logic [3:0] id;
	} rmc_fmap_t;

	function automatic logic [7:0] prefix_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0:    c = 8'h24; // $
			3'd1:    c = 8'h47; // G
			3'd2:    c = 8'h50; // P
			3'd3:    c = 8'h52; // R
			3'd4:    c = 8'h4D; // M
			3'd5:    c = 8'h43; // C
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// comma count -> output field
	function automatic rmc_fmap_t field_map(input logic [3:0] fnum);
		rmc_fmap_t m;
		m = '{keep_f: 1'b1, multi: 1'b0, id: FID_TIME};
		unique case (fnum)
			4'd1:    m = '{keep_f: 1'b1, multi: 1'b1, id: FID_TIME};
			4'd2:    m = '{keep_f: 1'b1, multi: 1'b0, id: FID_STATUS};
			4'd3:    m = '{keep_f: 1'b1, multi: 1'b1, id: FID_LAT};
			4'd4:    m = '{keep_f: 1'b1, multi: 1'b0, id: FID_NS};
			4'd5:    m = '{keep_f: 1'b1, multi: 1'b1, id: FID_LON};
			4'd6:    m = '{keep_f: 1'b1, multi: 1'b0, id: FID_EW};
			4'd7:    m = '{keep_f: 1'b1, multi: 1'b1, id: FID_SPEED};
			4'd8:    m = '{keep_f: 1'b1, multi: 1'b1, id: FID_COURSE};
			4'd10:   m = '{keep_f: 1'b1, multi: 1'b1, id: FID_MAGVAR};
			default: m = '{keep_f: 1'b0, multi: 1'b0, id: FID_TIME};
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/nmea_rmc_field_extractor.sv =====
// Top level of the RMC field extractor: input register, parser, result register.
// Depends on rmc_pkg, rmc_parse, rmc_out_reg.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | rx_byte
//  out     | out_valid / out_stall| kind, field_id, position, char_value, overlong
//
// One byte per cycle while in_stall is low; a character's result waits in the parser
// and loads into the result register when the next byte steps, a line end's on its own step.
// The parser consumes a byte from the input register when it yields no result or
// the result register is free; out_stall thus reaches in_stall in the same cycle.
// arst_n clears all control state and restarts the line; no clearing pass.
`default_nettype none

module nmea_rmc_field_extractor #(
	parameter int unsigned LINE_MAX    = rmc_pkg::LINE_MAX_DEF,
	parameter int unsigned FIELD_CHARS = rmc_pkg::FIELD_CHARS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            kind,
	output logic [3:0]      field_id,
	output logic [3:0]      position,
	output logic [7:0]      char_value,
	output logic            overlong
);
	import rmc_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       res_valid;
	rmc_res_t   res;
	rmc_res_t   res_q;
	logic       out_free;
	logic       go_s1;

	assign go_s1    = valid_s1 && (!res_valid || out_free);
	assign in_stall = valid_s1 && !go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			byte_s1 <= rx_byte;
	end

	rmc_parse #(
		.LINE_MAX   (LINE_MAX),
		.FIELD_CHARS(FIELD_CHARS)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (go_s1),
		.rx_byte  (byte_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	rmc_out_reg u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (go_s1 && res_valid),
		.res   (res),
		.stall (out_stall),
		.valid (out_valid),
		.free  (out_free),
		.res_q (res_q)
	);

	assign kind       = res_q.kind;
	assign field_id   = res_q.field_id;
	assign position   = res_q.position;
	assign char_value = res_q.char_value;
	assign overlong   = res_q.overlong;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("in_stall raised with empty input register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(go_s1 && res_valid) |-> !(out_valid && out_stall))
		else $error("result register overwritten while stalled");

	a_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_END) |->
			(field_id == 4'd0 && position == 4'd0 && char_value == 8'd0))
		else $error("sentence-end request carries character data");

	a_char_no_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_CHAR) |-> (!overlong && field_id <= FID_MAGVAR))
		else $error("malformed field character request");

endmodule

`default_nettype wire

// ===== rtl/rmc_parse.sv =====
// Per-byte sentence state: prefix match, comma count, field index and held character.
// Depends on rmc_pkg.
`default_nettype none

module rmc_parse #(
	parameter int unsigned LINE_MAX    = rmc_pkg::LINE_MAX_DEF,
	parameter int unsigned FIELD_CHARS = rmc_pkg::FIELD_CHARS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic [7:0]       rx_byte,
	output logic                  res_valid,
	output rmc_pkg::rmc_res_t     res
);
	import rmc_pkg::*;

	localparam int unsigned CIW = $clog2(FIELD_CHARS + 1);

	logic [7:0]     line_count_q, line_count_d;
	logic           prefix_ok_q, prefix_ok_d;
	logic [3:0]     field_number_q, field_number_d;
	logic [CIW-1:0] char_index_q, char_index_d;
	logic           held_valid_q, held_valid_d;
	logic [7:0]     held_char_q, held_char_d;
	logic [3:0]     held_field_q, held_field_d;
	logic [3:0]     held_position_q, held_position_d;
	logic           overflow_seen_q, overflow_seen_d;

	logic      is_lf;
	rmc_fmap_t fm;

	assign is_lf = (rx_byte == CH_LF);
	assign fm    = field_map(field_number_q);

	always_comb begin
		if (is_lf) begin
			res_valid = prefix_ok_q && (line_count_q >= MATCH_MIN);
			res       = '{kind: KIND_END, field_id: 4'd0, position: 4'd0,
			              char_value: 8'd0, overlong: overflow_seen_q};
		end else begin
			res_valid = held_valid_q;
			res       = '{kind: KIND_CHAR, field_id: held_field_q,
			              position: held_position_q, char_value: held_char_q,
			              overlong: 1'b0};
		end
	end

	always_comb begin
		line_count_d    = line_count_q;
		prefix_ok_d     = prefix_ok_q;
		field_number_d  = field_number_q;
		char_index_d    = char_index_q;
		held_valid_d    = 1'b0;
		held_char_d     = held_char_q;
		held_field_d    = held_field_q;
		held_position_d = held_position_q;
		overflow_seen_d = overflow_seen_q;
		if (is_lf) begin
			line_count_d    = 8'd0;
			prefix_ok_d     = 1'b1;
			field_number_d  = 4'd0;
			char_index_d    = '0;
			overflow_seen_d = 1'b0;
		end else begin
			if (line_count_q < PREFIX_LEN && rx_byte != prefix_char(line_count_q[2:0]))
				prefix_ok_d = 1'b0;
			if (line_count_q >= 8'(LINE_MAX))
				overflow_seen_d = 1'b1;
			if (line_count_q < COUNT_SAT)
				line_count_d = line_count_q + 8'd1;
			if (rx_byte == CH_COMMA) begin
				if (field_number_q < FLD_LAST)
					field_number_d = field_number_q + 4'd1;
				char_index_d = '0;
			end else if (prefix_ok_d && fm.keep_f
			             && !(field_number_q == 4'd1 && rx_byte == CH_DOT)) begin
				if (!fm.multi) begin
					held_valid_d    = 1'b1;
					held_char_d     = rx_byte;
					held_field_d    = fm.id;
					held_position_d = 4'd0;
				end else if (char_index_q < CIW'(FIELD_CHARS)) begin
					held_valid_d    = 1'b1;
					held_char_d     = rx_byte;
					held_field_d    = fm.id;
					held_position_d = 4'(char_index_q);
					char_index_d    = char_index_q + CIW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q    <= 8'd0;
			prefix_ok_q     <= 1'b1;
			field_number_q  <= 4'd0;
			char_index_q    <= '0;
			held_valid_q    <= 1'b0;
			overflow_seen_q <= 1'b0;
		end else if (step) begin
			line_count_q    <= line_count_d;
			prefix_ok_q     <= prefix_ok_d;
			field_number_q  <= field_number_d;
			char_index_q    <= char_index_d;
			held_valid_q    <= held_valid_d;
			overflow_seen_q <= overflow_seen_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			held_char_q     <= held_char_d;
			held_field_q    <= held_field_d;
			held_position_q <= held_position_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rmc_out_reg.sv =====
// Result register of the RMC field extractor, one request deep.
// Depends on rmc_pkg.
`default_nettype none

module rmc_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire rmc_pkg::rmc_res_t res,
	input  wire logic              stall,
	output logic                   valid,
	output logic                   free,
	output rmc_pkg::rmc_res_t      res_q
);
	import rmc_pkg::*;

	logic valid_q;

	assign valid = valid_q;
	assign free  = !valid_q || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res;
	end

endmodule

`default_nettype wire
